[rtl/rscp_pkg.sv]
// rscp_pkg: shared constants and types for the reid soft-core potential pipeline
// fixed-point scalings, series length, channel coefficients, sideband struct
// no dependencies
package rscp_pkg;

    // distance field, unsigned q3.13
    localparam int DIST_W = 16;
    localparam int DIST_FRAC = 13;

    // x = 0.7 * r with 32 fraction bits, below 2^35 for a 16-bit distance
    localparam int X_W = 35;
    localparam int N_W = 4;
    localparam int N_MAX = 8;

    localparam logic [31:0] K_POINT7 = 32'd3006477107;
    localparam logic [31:0] K_LN2 = 32'd2977044472;

    // taylor series length for exp(-t)
    localparam int SERIES_TERMS = 20;

    // channel coefficients, 16 fraction bits
    localparam logic [19:0] S0_C1 = 20'd685703;
    localparam logic [26:0] S0_C4 = 27'd108173722;
    localparam logic [28:0] S0_C7 = 29'd424948531;
    localparam logic [19:0] S1_C1 = 20'd228568;
    localparam logic [26:0] S1_C4 = 27'd61176545;
    localparam logic [28:0] S1_C6 = 29'd272112026;

    // divider operand widths
    localparam int DEN_W = X_W + 8;
    localparam int NUM_W = 62;

    // sideband carried through the exponential and power stages
    typedef struct packed {
        logic           zero;
        logic           spin;
        logic [N_W-1:0] n;
        logic [X_W-1:0] x;
    } side_t;

    // sideband carried through the divider
    typedef struct packed {
        logic zero;
        logic negative;
    } div_side_t;

endpackage

[rtl/rscp_exp.sv]
// rscp_exp: pipelined taylor series for exp(-t), t in [0, ln 2) with 32 fraction bits
// three register stages per term: multiply by t, multiply by reciprocal, correct and sum
// depends on rscp_pkg
module rscp_exp
    import rscp_pkg::*;
#(
    parameter int SW = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  logic [31:0]   in_t,
    input  logic [SW-1:0] in_side,
    output logic          out_valid,
    output logic [31:0]   out_m,
    output logic [SW-1:0] out_side
);

    // links between term sections
    logic          lk_valid [SERIES_TERMS+1];
    logic [32:0]   lk_term  [SERIES_TERMS+1];
    logic [33:0]   lk_sum   [SERIES_TERMS+1];
    logic [31:0]   lk_t     [SERIES_TERMS+1];
    logic [SW-1:0] lk_side  [SERIES_TERMS+1];

    logic          out_valid_reg;
    logic [31:0]   out_m_reg;
    logic [SW-1:0] out_side_reg;

    // series starts at one for both term and sum
    assign lk_valid[0] = in_valid;
    assign lk_term[0]  = 33'h1_0000_0000;
    assign lk_sum[0]   = 34'h1_0000_0000;
    assign lk_t[0]     = in_t;
    assign lk_side[0]  = in_side;

    for (genvar g = 0; g < SERIES_TERMS; g++) begin : g_term
        localparam int unsigned KV = g + 1;
        localparam logic [32:0] RECIP = 33'((64'd1 << 32) / KV);
        localparam logic [32:0] KDIV = 33'(KV);

        logic          a_valid_reg;
        logic [32:0]   a_p_reg;
        logic [31:0]   a_t_reg;
        logic [33:0]   a_sum_reg;
        logic [SW-1:0] a_side_reg;

        logic          b_valid_reg;
        logic [32:0]   b_q0_reg;
        logic [32:0]   b_p_reg;
        logic [31:0]   b_t_reg;
        logic [33:0]   b_sum_reg;
        logic [SW-1:0] b_side_reg;

        logic          c_valid_reg;
        logic [32:0]   c_term_reg;
        logic [33:0]   c_sum_reg;
        logic [31:0]   c_t_reg;
        logic [SW-1:0] c_side_reg;

        logic [64:0]   prod_a;
        logic [65:0]   prod_b;
        logic [32:0]   rem0;
        logic [32:0]   rem1;
        logic [32:0]   q1;
        logic [32:0]   term_next;
        logic [33:0]   sum_next;

        // term times t, and the quotient estimate by reciprocal
        assign prod_a = 65'(lk_term[g]) * 65'(lk_t[g]);
        assign prod_b = 66'(a_p_reg) * 66'(RECIP);

        // estimate is low by at most two, fix with two compare-subtracts
        always_comb
        begin
            rem0 = b_p_reg - b_q0_reg * KDIV;
            q1   = (rem0 >= KDIV) ? b_q0_reg + 33'd1 : b_q0_reg;
            rem1 = (rem0 >= KDIV) ? rem0 - KDIV : rem0;
            term_next = (rem1 >= KDIV) ? q1 + 33'd1 : q1;
            if (KV % 2 == 1)
            begin
                sum_next = b_sum_reg - {1'b0, term_next};
            end
            else
            begin
                sum_next = b_sum_reg + {1'b0, term_next};
            end
        end

        // valid bits of the three stages
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                a_valid_reg <= 1'b0;
                b_valid_reg <= 1'b0;
                c_valid_reg <= 1'b0;
            end
            else if (en)
            begin
                a_valid_reg <= lk_valid[g];
                b_valid_reg <= a_valid_reg;
                c_valid_reg <= b_valid_reg;
            end
        end

        // payload of the three stages
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                a_p_reg    <= prod_a[64:32];
                a_t_reg    <= lk_t[g];
                a_sum_reg  <= lk_sum[g];
                a_side_reg <= lk_side[g];

                b_q0_reg   <= prod_b[64:32];
                b_p_reg    <= a_p_reg;
                b_t_reg    <= a_t_reg;
                b_sum_reg  <= a_sum_reg;
                b_side_reg <= a_side_reg;

                c_term_reg <= term_next;
                c_sum_reg  <= sum_next;
                c_t_reg    <= b_t_reg;
                c_side_reg <= b_side_reg;
            end
        end

        assign lk_valid[g+1] = c_valid_reg;
        assign lk_term[g+1]  = c_term_reg;
        assign lk_sum[g+1]   = c_sum_reg;
        assign lk_t[g+1]     = c_t_reg;
        assign lk_side[g+1]  = c_side_reg;
    end

    // clamp to the 32-bit fraction range
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= lk_valid[SERIES_TERMS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_m_reg <= (lk_sum[SERIES_TERMS] > 34'h0_FFFF_FFFF) ? 32'hFFFF_FFFF
                                                                : lk_sum[SERIES_TERMS][31:0];
            out_side_reg <= lk_side[SERIES_TERMS];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_m     = out_m_reg;
    assign out_side  = out_side_reg;

endmodule

[rtl/rscp_div.sv]
// rscp_div: pipelined restoring divider, one quotient bit per stage
// a leading stage flags quotients that do not fit in QW bits
// no package dependencies
module rscp_div #(
    parameter int NUM_W = 62,
    parameter int DEN_W = 43,
    parameter int QW = 32,
    parameter int SW = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  logic [NUM_W-1:0] in_num,
    input  logic [DEN_W-1:0] in_den,
    input  logic [SW-1:0]    in_side,
    output logic             out_valid,
    output logic [QW-1:0]    out_q,
    output logic             out_over,
    output logic [SW-1:0]    out_side
);

    localparam int RW = (NUM_W > DEN_W + QW) ? NUM_W : DEN_W + QW;

    logic             lk_valid [QW+1];
    logic [RW-1:0]    lk_rem   [QW+1];
    logic [DEN_W-1:0] lk_den   [QW+1];
    logic [QW-1:0]    lk_q     [QW+1];
    logic             lk_over  [QW+1];
    logic [SW-1:0]    lk_side  [QW+1];

    logic             pre_valid_reg;
    logic [RW-1:0]    pre_rem_reg;
    logic [DEN_W-1:0] pre_den_reg;
    logic             pre_over_reg;
    logic [SW-1:0]    pre_side_reg;

    // overflow check against the first bit above the quotient
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pre_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            pre_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pre_rem_reg  <= RW'(in_num);
            pre_den_reg  <= in_den;
            pre_over_reg <= (RW'(in_num) >= (RW'(in_den) << QW));
            pre_side_reg <= in_side;
        end
    end

    assign lk_valid[0] = pre_valid_reg;
    assign lk_rem[0]   = pre_rem_reg;
    assign lk_den[0]   = pre_den_reg;
    assign lk_q[0]     = '0;
    assign lk_over[0]  = pre_over_reg;
    assign lk_side[0]  = pre_side_reg;

    for (genvar g = 0; g < QW; g++) begin : g_bit
        localparam int B = QW - 1 - g;

        logic             valid_reg;
        logic [RW-1:0]    rem_reg;
        logic [DEN_W-1:0] den_reg;
        logic [QW-1:0]    q_reg;
        logic             over_reg;
        logic [SW-1:0]    side_reg;

        logic [RW-1:0]    shifted;
        logic             take;
        logic [QW-1:0]    q_next;

        // compare and subtract at this bit weight
        always_comb
        begin
            shifted   = RW'(lk_den[g]) << B;
            take      = (lk_rem[g] >= shifted);
            q_next    = lk_q[g];
            q_next[B] = take;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg <= 1'b0;
            end
            else if (en)
            begin
                valid_reg <= lk_valid[g];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg  <= take ? lk_rem[g] - shifted : lk_rem[g];
                den_reg  <= lk_den[g];
                q_reg    <= q_next;
                over_reg <= lk_over[g];
                side_reg <= lk_side[g];
            end
        end

        assign lk_valid[g+1] = valid_reg;
        assign lk_rem[g+1]   = rem_reg;
        assign lk_den[g+1]   = den_reg;
        assign lk_q[g+1]     = q_reg;
        assign lk_over[g+1]  = over_reg;
        assign lk_side[g+1]  = side_reg;
    end

    assign out_valid = lk_valid[QW];
    assign out_q     = lk_q[QW];
    assign out_over  = lk_over[QW];
    assign out_side  = lk_side[QW];

endmodule

[rtl/reid_soft_core_potential.sv]
// reid_soft_core_potential: singlet/triplet reid soft-core potential, fully pipelined
// throughput: one transfer per cycle unless the output buffer is full; the 20-term
// exp series (60 stages) and the one-bit-per-stage divider set the depth; a
// two-entry output buffer absorbs stalls
// reset: rst_n clears all valid bits and the output buffer; no other state
// depends on rscp_pkg, rscp_exp, rscp_div
module reid_soft_core_potential
    import rscp_pkg::*;
#(
    parameter int POTENTIAL_WIDTH = 32
) (
    input  logic                                           clk,
    input  logic                                           rst_n,
    input  logic                                           s_tvalid,
    output logic                                           s_tready,
    // distance [15:0]
    input  logic [DIST_W-1:0]                              s_tdata,
    // spin_channel [0]
    input  logic                                           s_tuser,
    output logic                                           m_tvalid,
    input  logic                                           m_tready,
    // potential [POTENTIAL_WIDTH-1:0], zero filled to whole bytes
    output logic [((POTENTIAL_WIDTH + 7) / 8) * 8 - 1:0]  m_tdata,
    // zero_distance [0], saturated [1]
    output logic [1:0]                                     m_tuser
);

    localparam int PW = POTENTIAL_WIDTH;
    localparam int OUT_TW = ((POTENTIAL_WIDTH + 7) / 8) * 8;
    localparam logic [PW-1:0] LIM_POS = {1'b0, {(PW - 1){1'b1}}};
    localparam logic [PW-1:0] LIM_NEG = {1'b1, {(PW - 1){1'b0}}};
    localparam logic [1:0] BUF_FULL = 2'd2;

    typedef struct packed {
        logic          saturated;
        logic          zero_distance;
        logic [PW-1:0] potential;
    } result_t;

    // rounded q32 product
    function automatic logic [31:0] mul_q32(input logic [31:0] a, input logic [31:0] b);
        logic [63:0] p;
        p = 64'(a) * 64'(b) + 64'h8000_0000;
        return p[63:32];
    endfunction

    // right shift by n*k, zero once the shift passes the word
    function automatic logic [31:0] shr_pow(input logic [31:0] v, input logic [N_W-1:0] n,
                                            input logic [2:0] k);
        logic [5:0] amt;
        amt = 6'(n) * 6'(k);
        return (amt >= 6'd32) ? 32'd0 : (v >> amt[4:0]);
    endfunction

    logic en;
    logic push;
    logic pop;

    // input stage
    logic              s1_valid_reg;
    logic [DIST_W-1:0] s1_dist_reg;
    logic              s1_spin_reg;

    // x stage
    logic              s2_valid_reg;
    logic [X_W-1:0]    s2_x_reg;
    logic              s2_spin_reg;
    logic              s2_zero_reg;
    logic [47:0]       x_full;

    // range reduction stages
    logic              s3_valid_reg;
    logic [X_W-1:0]    s3_x_reg;
    logic [N_W-1:0]    s3_n_reg;
    logic              s3_spin_reg;
    logic              s3_zero_reg;
    logic [N_W-1:0]    n_next;

    logic              s4_valid_reg;
    logic [31:0]       s4_t_reg;
    side_t             s4_side_reg;
    logic [X_W-1:0]    t_next;

    // exponential
    logic              ex_valid;
    logic [31:0]       ex_m;
    logic [$bits(side_t)-1:0] ex_side_bits;
    side_t             ex_side;

    // power chain
    logic              pw_valid_reg [6];
    logic [31:0]       pw_pow_reg   [6];
    logic [31:0]       pw_base_reg  [6];
    side_t             pw_side_reg  [6];
    logic [31:0]       pw_p4_reg    [3:5];
    logic [31:0]       pw_p6_reg;

    // scaled powers
    logic              sh_valid_reg;
    logic [31:0]       sh_e1_reg;
    logic [31:0]       sh_e4_reg;
    logic [31:0]       sh_eh_reg;
    logic              sh_spin_reg;
    logic              sh_zero_reg;
    logic [X_W-1:0]    sh_x_reg;

    // coefficient products
    logic              mu_valid_reg;
    logic [51:0]       mu_a1_reg;
    logic [58:0]       mu_a4_reg;
    logic [60:0]       mu_ah_reg;
    logic              mu_zero_reg;
    logic [X_W-1:0]    mu_x_reg;

    // magnitude and sign
    logic              mg_valid_reg;
    logic [60:0]       mg_mag_reg;
    logic              mg_neg_reg;
    logic              mg_zero_reg;
    logic [X_W-1:0]    mg_x_reg;
    logic [60:0]       neg_sum;

    // rounded numerator and denominator
    logic              nm_valid_reg;
    logic [NUM_W-1:0]  nm_num_reg;
    logic [DEN_W-1:0]  nm_den_reg;
    div_side_t         nm_side_reg;

    // divider outputs
    logic              dv_valid;
    logic [PW-1:0]     dv_q;
    logic              dv_over;
    logic [$bits(div_side_t)-1:0] dv_side_bits;
    div_side_t         dv_side;
    result_t           res;

    // output buffer
    logic [1:0]        cnt_reg;
    result_t           out_reg;
    result_t           skid_reg;

    // pipeline advances unless the output buffer is full
    assign en = (cnt_reg != BUF_FULL);
    assign s_tready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= s_tvalid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    // x = 0.7 * r, rounded to 32 fraction bits
    assign x_full = 48'(s1_dist_reg) * 48'(K_POINT7) + 48'(1 << (DIST_FRAC - 1));

    // n = floor(x / ln 2) by comparison with its multiples
    always_comb
    begin
        n_next = '0;
        for (int j = 1; j <= N_MAX; j++)
        begin
            if (s2_x_reg >= X_W'(j) * X_W'(K_LN2))
            begin
                n_next = N_W'(j);
            end
        end
    end

    assign t_next = s3_x_reg - X_W'(s3_n_reg) * X_W'(K_LN2);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_dist_reg <= s_tdata;
            s1_spin_reg <= s_tuser;

            s2_x_reg    <= x_full[47:DIST_FRAC];
            s2_spin_reg <= s1_spin_reg;
            s2_zero_reg <= (s1_dist_reg == '0);

            s3_x_reg    <= s2_x_reg;
            s3_n_reg    <= n_next;
            s3_spin_reg <= s2_spin_reg;
            s3_zero_reg <= s2_zero_reg;

            s4_t_reg         <= t_next[31:0];
            s4_side_reg.zero <= s3_zero_reg;
            s4_side_reg.spin <= s3_spin_reg;
            s4_side_reg.n    <= s3_n_reg;
            s4_side_reg.x    <= s3_x_reg;
        end
    end

    rscp_exp #(
        .SW($bits(side_t))
    ) u_exp (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (s4_valid_reg),
        .in_t     (s4_t_reg),
        .in_side  (s4_side_reg),
        .out_valid(ex_valid),
        .out_m    (ex_m),
        .out_side (ex_side_bits)
    );

    assign ex_side = side_t'(ex_side_bits);

    // powers m^2 .. m^7, one rounded product per stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < 6; s++)
            begin
                pw_valid_reg[s] <= 1'b0;
            end
        end
        else if (en)
        begin
            pw_valid_reg[0] <= ex_valid;
            for (int s = 1; s < 6; s++)
            begin
                pw_valid_reg[s] <= pw_valid_reg[s-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pw_pow_reg[0]  <= mul_q32(ex_m, ex_m);
            pw_base_reg[0] <= ex_m;
            pw_side_reg[0] <= ex_side;
            for (int s = 1; s < 6; s++)
            begin
                pw_pow_reg[s]  <= mul_q32(pw_pow_reg[s-1], pw_base_reg[s-1]);
                pw_base_reg[s] <= pw_base_reg[s-1];
                pw_side_reg[s] <= pw_side_reg[s-1];
            end
            pw_p4_reg[3] <= pw_pow_reg[2];
            pw_p4_reg[4] <= pw_p4_reg[3];
            pw_p4_reg[5] <= pw_p4_reg[4];
            pw_p6_reg    <= pw_pow_reg[4];
        end
    end

    // scale by 2^-(k*n) and pick the channel's high power
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sh_valid_reg <= 1'b0;
            mu_valid_reg <= 1'b0;
            mg_valid_reg <= 1'b0;
            nm_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            sh_valid_reg <= pw_valid_reg[5];
            mu_valid_reg <= sh_valid_reg;
            mg_valid_reg <= mu_valid_reg;
            nm_valid_reg <= mg_valid_reg;
        end
    end

    assign neg_sum = 61'(mu_a1_reg) + 61'(mu_a4_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sh_e1_reg   <= shr_pow(pw_base_reg[5], pw_side_reg[5].n, 3'd1);
            sh_e4_reg   <= shr_pow(pw_p4_reg[5], pw_side_reg[5].n, 3'd4);
            sh_eh_reg   <= pw_side_reg[5].spin ? shr_pow(pw_p6_reg, pw_side_reg[5].n, 3'd6)
                                               : shr_pow(pw_pow_reg[5], pw_side_reg[5].n, 3'd7);
            sh_spin_reg <= pw_side_reg[5].spin;
            sh_zero_reg <= pw_side_reg[5].zero;
            sh_x_reg    <= pw_side_reg[5].x;

            // coefficient products
            mu_a1_reg   <= 52'(sh_spin_reg ? S1_C1 : S0_C1) * 52'(sh_e1_reg);
            mu_a4_reg   <= 59'(sh_spin_reg ? S1_C4 : S0_C4) * 59'(sh_e4_reg);
            mu_ah_reg   <= 61'(sh_spin_reg ? S1_C6 : S0_C7) * 61'(sh_eh_reg);
            mu_zero_reg <= sh_zero_reg;
            mu_x_reg    <= sh_x_reg;

            // signed sum as magnitude and sign
            if (mu_ah_reg >= neg_sum)
            begin
                mg_mag_reg <= mu_ah_reg - neg_sum;
                mg_neg_reg <= 1'b0;
            end
            else
            begin
                mg_mag_reg <= neg_sum - mu_ah_reg;
                mg_neg_reg <= 1'b1;
            end
            mg_zero_reg <= mu_zero_reg;
            mg_x_reg    <= mu_x_reg;

            // add half the divisor for round to nearest
            nm_num_reg           <= NUM_W'(mg_mag_reg) + (NUM_W'(mg_x_reg) << 7);
            nm_den_reg           <= {mg_x_reg, 8'd0};
            nm_side_reg.zero     <= mg_zero_reg;
            nm_side_reg.negative <= mg_neg_reg;
        end
    end

    rscp_div #(
        .NUM_W(NUM_W),
        .DEN_W(DEN_W),
        .QW   (PW),
        .SW   ($bits(div_side_t))
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (nm_valid_reg),
        .in_num   (nm_num_reg),
        .in_den   (nm_den_reg),
        .in_side  (nm_side_reg),
        .out_valid(dv_valid),
        .out_q    (dv_q),
        .out_over (dv_over),
        .out_side (dv_side_bits)
    );

    assign dv_side = div_side_t'(dv_side_bits);

    // clamp, apply sign, zero-distance override
    always_comb
    begin
        res = '0;
        if (dv_side.zero)
        begin
            res.zero_distance = 1'b1;
        end
        else if (!dv_side.negative)
        begin
            if (dv_over || (dv_q > LIM_POS))
            begin
                res.potential = LIM_POS;
                res.saturated = 1'b1;
            end
            else
            begin
                res.potential = dv_q;
            end
        end
        else
        begin
            if (dv_over || (dv_q > LIM_NEG))
            begin
                res.potential = LIM_NEG;
                res.saturated = 1'b1;
            end
            else
            begin
                res.potential = -dv_q;
            end
        end
    end

    // two-entry output buffer
    assign push = en && dv_valid;
    assign pop  = (cnt_reg != 2'd0) && m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && ((cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && pop)))
        begin
            out_reg <= res;
        end
        else if (pop && (cnt_reg == BUF_FULL))
        begin
            out_reg <= skid_reg;
        end
        if (push && (cnt_reg == 2'd1) && !pop)
        begin
            skid_reg <= res;
        end
    end

    assign m_tvalid = (cnt_reg != 2'd0);
    assign m_tdata  = OUT_TW'(out_reg.potential);
    assign m_tuser  = {out_reg.saturated, out_reg.zero_distance};

`ifndef ASSERT_OFF
    a_zero_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && out_reg.zero_distance) |-> (out_reg.potential == '0 && !out_reg.saturated))
        else $error("zero distance result not cleared");

    a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && out_reg.saturated) |->
        (out_reg.potential == LIM_POS || out_reg.potential == LIM_NEG))
        else $error("saturated result not at a range end");

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3)
        else $error("output buffer count out of range");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (cnt_reg != BUF_FULL))
        else $error("transfer into full output buffer");
`endif

endmodule
